[rtl/sib_pkg.sv]
`default_nettype none

package sib_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int CNT_OUT_W    = 5;
  localparam int CAP_REG_W    = 5;
  localparam int CFG_W        = 5;

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_FRONT  = 3'd1,
    MODE_SORTED = 3'd2,
    MODE_POS    = 3'd3,
    MODE_NEG    = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic {
    REG_MODE     = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_idx_t;

  localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic ins_front;
    logic ins_append;
    logic ins_sorted;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/sib_cell.sv]
`default_nettype none

module sib_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire                          clk,
  input  wire sib_pkg::cell_ctrl_t     ctrl,
  input  wire [sib_pkg::DATA_W-1:0]    ins_value,
  input  wire [CNT_W-1:0]              count,
  input  wire [sib_pkg::DATA_W-1:0]    left_entry,
  input  wire                          left_le,
  input  wire                          right_any,
  output logic [sib_pkg::DATA_W-1:0]   entry,
  output logic                         le,
  output logic                         any_le
);
  import sib_pkg::*;

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;
  logic              valid;

  assign valid  = CNT_W'(IDX) < count;
  assign le     = valid && ($signed(entry_r) <= $signed(ins_value));
  assign any_le = le || right_any;
  assign entry  = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl.ins_front) begin
      entry_nxt = left_entry;
    end else if (ctrl.ins_append) begin
      if (count == CNT_W'(IDX)) begin
        entry_nxt = ins_value;
      end
    end else if (ctrl.ins_sorted) begin
      if (!any_le) begin
        entry_nxt = left_le ? ins_value : left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

[rtl/sorted_insertion_buffer_top.sv]
`default_nettype none

// Sorted insertion buffer of signed Q16.16 values, held in a row of cells.
// Input channel: in_valid/in_ready carry one request with in_opcode (insert,
// read or clear), in_value and in_read_index. Each request gives exactly one
// result on the out_valid/out_ready channel with the insert flags, the entry
// count after the request and, for a read, the entry at the requested index.
// out_valid rises in the cycle after acceptance, and one request is taken
// every cycle while the receiver does not stall; every cell compares and shifts
// in parallel, so an insert of any kind completes in the cycle it is accepted.
// Configuration: cfg_wr_en writes cfg_wdata into the register at cfg_index
// (0 insert mode, 1 capacity in use); the user must make writes only while idle;
// the block does not enforce it. Reset empties the buffer and sets sorted mode
// with capacity 16, clamped to CAPACITY. On a receiver stall, the result register
// holds its contents and in_ready stays low until the result has been taken.

module sorted_insertion_buffer_top #(
  parameter int CAPACITY = sib_pkg::CAPACITY_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [1:0]                          in_opcode,
  input  wire  signed [sib_pkg::DATA_W-1:0]   in_value,
  input  wire  [3:0]                          in_read_index,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic                                out_accepted,
  output logic                                out_rejected_by_sign,
  output logic                                out_dropped_full,
  output logic [sib_pkg::CNT_OUT_W-1:0]       out_entry_count,
  output logic signed [sib_pkg::DATA_W-1:0]   out_read_value,
  output logic                                out_read_valid,
  input  wire                                 cfg_wr_en,
  input  wire                                 cfg_index,
  input  wire  [sib_pkg::CFG_W-1:0]           cfg_wdata
);
  import sib_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > CAP_REG_W) ? CNT_W : CAP_REG_W;

  logic [2:0]           mode_r;
  logic [CAP_REG_W-1:0] cap_r;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic                 out_valid_r;
  logic                 out_acc_r, out_rej_r, out_full_r, out_rvalid_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic [DATA_W-1:0]    out_rval_r;

  logic [CMP_W-1:0]     cap_ext, cap_eff, count_ext, rd_idx_ext;
  logic                 in_fire, is_insert, is_front, is_append, sign_rej, full;
  logic                 acc, rd_hit;
  logic [DATA_W-1:0]    rd_data;
  cell_ctrl_t           ctrl;

  logic [DATA_W-1:0]    entry_w      [CAPACITY];
  logic [DATA_W-1:0]    left_entry_w [CAPACITY];
  logic                 le_w         [CAPACITY];
  logic                 left_le_w    [CAPACITY];
  logic                 any_w        [CAPACITY];
  logic                 right_any_w  [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SORTED;
      cap_r  <= CAP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE:     mode_r <= cfg_wdata[2:0];
        REG_CAPACITY: cap_r  <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    cap_ext   = CMP_W'(cap_r);
    count_ext = CMP_W'(count_r);
    priority if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(CAPACITY)) begin
      cap_eff = CMP_W'(CAPACITY);
    end else begin
      cap_eff = cap_ext;
    end
    full = count_ext >= cap_eff;
  end

  always_comb begin
    is_front  = 1'b0;
    is_append = 1'b0;
    sign_rej  = 1'b0;
    unique case (mode_r)
      MODE_APPEND: is_append = 1'b1;
      MODE_FRONT:  is_front  = 1'b1;
      MODE_POS:    sign_rej  = !(in_value > 0);
      MODE_NEG:    sign_rej  = !(in_value < 0);
      default:     ;
    endcase
  end

  always_comb begin
    is_insert       = in_fire && (in_opcode == OP_INSERT);
    acc             = is_front || (!sign_rej && !full);
    ctrl.ins_front  = is_insert && is_front;
    ctrl.ins_append = is_insert && is_append && !full;
    ctrl.ins_sorted = is_insert && !is_front && !is_append && !sign_rej && !full;

    count_nxt = count_r;
    if (in_fire) begin
      unique case (in_opcode)
        OP_INSERT: begin
          if (is_front) begin
            count_nxt = (count_ext < cap_eff) ? count_r + CNT_W'(1) : CNT_W'(cap_eff);
          end else if (acc) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_CLEAR: count_nxt = '0;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_entry_w[g] = in_value;
      assign left_le_w[g]    = 1'b1;
    end else begin : g_rest
      assign left_entry_w[g] = entry_w[g-1];
      assign left_le_w[g]    = le_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_any_w[g] = 1'b0;
    end else begin : g_inner
      assign right_any_w[g] = any_w[g+1];
    end

    sib_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .ins_value  (in_value),
      .count      (count_r),
      .left_entry (left_entry_w[g]),
      .left_le    (left_le_w[g]),
      .right_any  (right_any_w[g]),
      .entry      (entry_w[g]),
      .le         (le_w[g]),
      .any_le     (any_w[g])
    );
  end

  always_comb begin
    rd_idx_ext = CMP_W'(in_read_index);
    rd_hit     = rd_idx_ext < count_ext;
    rd_data    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_idx_ext == CMP_W'(i)) begin
        rd_data = entry_w[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_acc_r    <= is_insert && acc;
      out_rej_r    <= is_insert && !is_front && sign_rej;
      out_full_r   <= is_insert && !is_front && !sign_rej && full;
      out_count_r  <= CNT_OUT_W'(count_nxt);
      out_rvalid_r <= (in_opcode == OP_READ) && rd_hit;
      out_rval_r   <= ((in_opcode == OP_READ) && rd_hit) ? rd_data : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = out_acc_r;
  assign out_rejected_by_sign = out_rej_r;
  assign out_dropped_full     = out_full_r;
  assign out_entry_count      = out_count_r;
  assign out_read_value       = out_rval_r;
  assign out_read_valid       = out_rvalid_r;

endmodule

`default_nettype wire

[rtl/sib_checker.sv]
`default_nettype none

module sib_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_ready,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire                                out_accepted,
  input wire                                out_rejected_by_sign,
  input wire                                out_dropped_full,
  input wire                                out_read_valid,
  input wire signed [sib_pkg::DATA_W-1:0]   out_read_value
);

  // A stalled result stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Every accepted request produces a result in the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result one cycle after an accepted request");

  // An insert has exactly one outcome at most.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_accepted, out_rejected_by_sign, out_dropped_full}))
    else $error("conflicting insert flags");

  // A read result never carries insert flags.
  a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |->
      !out_accepted && !out_rejected_by_sign && !out_dropped_full)
    else $error("read result carries insert flags");

  // Without a valid read the value returned is zero.
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |-> out_read_value == '0)
    else $error("non-zero read value without a valid read");

endmodule

bind sorted_insertion_buffer_top sib_checker u_sib_checker (.*);

`default_nettype wire
